// File: sv/smc_pkg.sv
// Package for the stack machine core: command and status codes, queue entry type.
// Used by smc_front, smc_divider, smc_back and stack_machine_core; depends on nothing.
`default_nettype none
package smc_pkg;
  localparam int CMD_W = 3;
  localparam int IMM_W = 32;
  localparam int ADDR_W = 7;
  localparam int WORD_W = 64;
  localparam int ST_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 3'd0,
    CMD_LOAD  = 3'd1,
    CMD_STORE = 3'd2,
    CMD_ADD   = 3'd3,
    CMD_SUB   = 3'd4,
    CMD_MUL   = 3'd5,
    CMD_DIV   = 3'd6,
    CMD_PRINT = 3'd7
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_PRINT = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  // One decoded instruction as it travels from the front to the back.
  typedef struct packed {
    cmd_t              cmd;
    logic [WORD_W-1:0] imm;
    logic [ADDR_W-1:0] addr;
    logic              pops_one;
    logic              pops_two;
    logic              pushes;
  } instr_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_READ,
    BK_READ2,
    BK_EXEC,
    BK_MUL,
    BK_MUL2,
    BK_MUL3,
    BK_DIV,
    BK_DIVFIX,
    BK_WRITE,
    BK_EMIT
  } bk_state_t;
endpackage
`default_nettype wire

// File: sv/smc_front.sv
// Front end of the stack machine core: accepts instructions, decodes them and
// holds them in a two-entry queue for the back end. Depends on smc_pkg.
`default_nettype none
module smc_front (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire  [smc_pkg::CMD_W-1:0]     in_command,
  input  wire  signed [smc_pkg::IMM_W-1:0] in_immediate,
  input  wire  [smc_pkg::ADDR_W-1:0]    in_address,
  output logic                          q_valid,
  output smc_pkg::instr_t               q_data,
  input  wire                           q_take
);
  smc_pkg::instr_t q_mem_r [2];
  logic            wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  smc_pkg::instr_t dec;
  logic            push_en, pop_en;

  always_comb begin
    dec.cmd  = smc_pkg::cmd_t'(in_command);
    dec.imm  = {{(smc_pkg::WORD_W-smc_pkg::IMM_W){in_immediate[smc_pkg::IMM_W-1]}},
                in_immediate};
    dec.addr = in_address;
    dec.pushes   = (dec.cmd == smc_pkg::CMD_PUSH) || (dec.cmd == smc_pkg::CMD_LOAD);
    dec.pops_one = (dec.cmd == smc_pkg::CMD_STORE) || (dec.cmd == smc_pkg::CMD_PRINT);
    dec.pops_two = !dec.pushes && !dec.pops_one;
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push_en  = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = q_mem_r[rp_r];
  assign pop_en   = q_valid && q_take;

  always_comb begin
    wp_nxt  = push_en ? !wp_r : wp_r;
    rp_nxt  = pop_en ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push_en} - {1'b0, pop_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      q_mem_r[wp_r] <= dec;
    end
  end
endmodule
`default_nettype wire

// File: sv/smc_divider.sv
// Iterative unsigned 64-bit divider, one quotient bit per cycle.
// Depends on smc_pkg for the word width.
`default_nettype none
module smc_divider (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire  [smc_pkg::WORD_W-1:0]   dividend,
  input  wire  [smc_pkg::WORD_W-1:0]   divisor,
  output logic                         done,
  output logic [smc_pkg::WORD_W-1:0]   quotient
);
  localparam int W = smc_pkg::WORD_W;
  localparam int CW = $clog2(W + 1);
  logic [W-1:0]  quo_r, quo_nxt, dsr_r, dsr_nxt;
  logic [W:0]    rem_r, rem_nxt, trial;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;

  always_comb begin
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[W-1:0], quo_r[W-1]} - {1'b0, dsr_r};
    if (start) begin
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[W]) begin
        rem_nxt = trial;
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[W-1:0], quo_r[W-1]};
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = busy_r && (cnt_r == CW'(1));
  assign quotient = quo_nxt;
endmodule
`default_nettype wire

// File: sv/smc_back.sv
// Back end of the stack machine core: operand stack, data memory, ALU sequencing
// and the result register. Depends on smc_pkg and smc_divider.
`default_nettype none
module smc_back #(
  parameter int STACK_DEPTH = 256,
  parameter int MEM_DEPTH   = 128
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          q_valid,
  input  wire smc_pkg::instr_t         q_data,
  output logic                         q_take,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic signed [smc_pkg::WORD_W-1:0] out_value,
  output logic [smc_pkg::ST_W-1:0]     out_status,
  output logic                         clearing
);
  localparam int W   = smc_pkg::WORD_W;
  localparam int HW  = W / 2;
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int MAW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int MCW = $clog2(MEM_DEPTH + 1);
  localparam int AW  = smc_pkg::ADDR_W;

  logic [W-1:0] stk_mem [STACK_DEPTH];
  logic [W-1:0] dmem [MEM_DEPTH];

  smc_pkg::bk_state_t st_r, st_nxt;
  smc_pkg::instr_t    ins_r;
  logic [SPW-1:0]     sp_r, sp_nxt;
  logic [MCW-1:0]     clr_r, clr_nxt;
  logic [W-1:0]       a_r, b_r, res_r, res_nxt, mrd_r, srd_r;
  logic               in_mem_r;
  logic               ov_r, ov_nxt;
  logic [W-1:0]       ov_val_r, ov_val_nxt;
  logic [smc_pkg::ST_W-1:0] ov_st_r, ov_st_nxt;
  logic               neg_r;

  // Read and write controls, decided in the output block.
  logic               s_rd;
  logic [SAW-1:0]     s_raddr;
  logic               s_we;
  logic [SAW-1:0]     s_waddr;
  logic [W-1:0]       s_wdata;
  logic               m_we;
  logic [MAW-1:0]     m_waddr;
  logic [W-1:0]       m_wdata;
  logic               emit;
  logic [W-1:0]       emit_val;
  smc_pkg::status_t   emit_st;
  logic               div_start, div_done;
  logic [W-1:0]       div_q, mag_a, mag_b;
  logic               addr_ok;
  logic [HW-1:0]      mul_x, mul_y;
  logic [W-1:0]       mul_p;

  assign clearing  = (clr_r != MCW'(MEM_DEPTH));
  assign addr_ok   = ({{(32-AW){1'b0}}, ins_r.addr} < 32'(MEM_DEPTH));
  assign mag_a     = a_r[W-1] ? (W'(0) - a_r) : a_r;
  assign mag_b     = b_r[W-1] ? (W'(0) - b_r) : b_r;
  assign out_valid = ov_r;
  assign out_value = ov_val_r;
  assign out_status = ov_st_r;
  assign mul_p     = mul_x * mul_y;

  smc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag_b),
    .divisor  (mag_a),
    .done     (div_done),
    .quotient (div_q)
  );

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      smc_pkg::BK_IDLE: begin
        if (q_valid && !clearing && !ov_r) st_nxt = smc_pkg::BK_READ;
      end
      smc_pkg::BK_READ: begin
        if (ins_r.pushes) begin
          st_nxt = (sp_r >= SPW'(STACK_DEPTH)) ? smc_pkg::BK_EMIT : smc_pkg::BK_WRITE;
        end else if (ins_r.pops_one) begin
          st_nxt = (sp_r == '0) ? smc_pkg::BK_EMIT : smc_pkg::BK_WRITE;
        end else begin
          st_nxt = (sp_r < SPW'(2)) ? smc_pkg::BK_EMIT : smc_pkg::BK_READ2;
        end
      end
      smc_pkg::BK_READ2: st_nxt = smc_pkg::BK_EXEC;
      smc_pkg::BK_EXEC: begin
        unique case (ins_r.cmd)
          smc_pkg::CMD_MUL: st_nxt = smc_pkg::BK_MUL;
          smc_pkg::CMD_DIV:
            st_nxt = (a_r == '0) ? smc_pkg::BK_EMIT : smc_pkg::BK_DIV;
          default: st_nxt = smc_pkg::BK_WRITE;
        endcase
      end
      smc_pkg::BK_MUL:    st_nxt = smc_pkg::BK_MUL2;
      smc_pkg::BK_MUL2:   st_nxt = smc_pkg::BK_MUL3;
      smc_pkg::BK_MUL3:   st_nxt = smc_pkg::BK_WRITE;
      smc_pkg::BK_DIV:    if (div_done) st_nxt = smc_pkg::BK_DIVFIX;
      smc_pkg::BK_DIVFIX: st_nxt = smc_pkg::BK_WRITE;
      smc_pkg::BK_WRITE: begin
        st_nxt = (ins_r.cmd == smc_pkg::CMD_PRINT) ? smc_pkg::BK_EMIT : smc_pkg::BK_IDLE;
      end
      smc_pkg::BK_EMIT:   st_nxt = smc_pkg::BK_IDLE;
      default:            st_nxt = smc_pkg::BK_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    q_take    = 1'b0;
    s_rd      = 1'b0;
    s_raddr   = '0;
    s_we      = 1'b0;
    s_waddr   = '0;
    s_wdata   = '0;
    m_we      = 1'b0;
    m_waddr   = '0;
    m_wdata   = a_r;
    emit      = 1'b0;
    emit_val  = '0;
    emit_st   = smc_pkg::ST_PRINT;
    div_start = 1'b0;
    sp_nxt    = sp_r;
    res_nxt   = res_r;
    clr_nxt   = clr_r;
    mul_x     = a_r[HW-1:0];
    mul_y     = b_r[HW-1:0];
    if (clearing) begin
      m_we    = 1'b1;
      m_waddr = MAW'(clr_r);
      m_wdata = '0;
      clr_nxt = clr_r + 1'b1;
    end
    unique case (st_r)
      smc_pkg::BK_IDLE: begin
        q_take = q_valid && !clearing && !ov_r;
        s_rd    = 1'b1;
        s_raddr = SAW'(sp_r - 1'b1);
      end
      smc_pkg::BK_READ: begin
        s_rd    = 1'b1;
        s_raddr = SAW'(sp_r - SPW'(2));
      end
      smc_pkg::BK_READ2: ;
      smc_pkg::BK_EXEC: begin
        unique case (ins_r.cmd)
          smc_pkg::CMD_ADD: res_nxt = a_r + b_r;
          smc_pkg::CMD_SUB: res_nxt = b_r - a_r;
          smc_pkg::CMD_DIV: div_start = (a_r != '0);
          default: ;
        endcase
      end
      // The low word of the product is built from three half-width products,
      // one per cycle; the high-by-high term only reaches bits above the word.
      smc_pkg::BK_MUL:    res_nxt = mul_p;
      smc_pkg::BK_MUL2: begin
        mul_y   = b_r[W-1:HW];
        res_nxt = res_r + {mul_p[HW-1:0], {HW{1'b0}}};
      end
      smc_pkg::BK_MUL3: begin
        mul_x   = a_r[W-1:HW];
        res_nxt = res_r + {mul_p[HW-1:0], {HW{1'b0}}};
      end
      smc_pkg::BK_DIV:    res_nxt = div_q;
      smc_pkg::BK_DIVFIX: res_nxt = neg_r ? (W'(0) - res_r) : res_r;
      smc_pkg::BK_WRITE: begin
        if (ins_r.pushes) begin
          s_we    = 1'b1;
          s_waddr = SAW'(sp_r);
          if (ins_r.cmd == smc_pkg::CMD_PUSH) s_wdata = ins_r.imm;
          else s_wdata = in_mem_r ? mrd_r : '0;
          sp_nxt  = sp_r + 1'b1;
        end else if (ins_r.pops_one) begin
          sp_nxt = sp_r - 1'b1;
          if (ins_r.cmd == smc_pkg::CMD_STORE && addr_ok) begin
            m_we    = 1'b1;
            m_waddr = MAW'(ins_r.addr);
          end
        end else begin
          s_we    = 1'b1;
          s_waddr = SAW'(sp_r - SPW'(2));
          s_wdata = res_r;
          sp_nxt  = sp_r - 1'b1;
        end
      end
      smc_pkg::BK_EMIT: begin
        emit = 1'b1;
        if (ins_r.cmd == smc_pkg::CMD_PRINT && sp_r != SPW'(STACK_DEPTH)
            && res_r == W'(1)) begin
          emit_val = a_r;
        end
        if (ins_r.pushes) emit_st = smc_pkg::ST_OVER;
        else if (ins_r.cmd == smc_pkg::CMD_DIV && a_r == '0 && sp_r >= SPW'(2))
          emit_st = smc_pkg::ST_DIVZ;
        else emit_st = smc_pkg::ST_UNDER;
        if (res_r == W'(1)) begin
          emit_st  = smc_pkg::ST_PRINT;
          emit_val = a_r;
        end
      end
      default: ;
    endcase
    // A print that reached WRITE marks its result as a successful pop.
    if (st_r == smc_pkg::BK_WRITE && ins_r.cmd == smc_pkg::CMD_PRINT) res_nxt = W'(1);
    if (st_r == smc_pkg::BK_IDLE) res_nxt = '0;
  end

  always_comb begin
    ov_nxt     = ov_r;
    ov_val_nxt = ov_val_r;
    ov_st_nxt  = ov_st_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    if (emit) begin
      ov_nxt     = 1'b1;
      ov_val_nxt = emit_val;
      ov_st_nxt  = emit_st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= smc_pkg::BK_IDLE;
      sp_r  <= '0;
      clr_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      sp_r  <= sp_nxt;
      clr_r <= clr_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r    <= res_nxt;
    ov_val_r <= ov_val_nxt;
    ov_st_r  <= ov_st_nxt;
    if (q_take) ins_r <= q_data;
    if (st_r == smc_pkg::BK_READ) a_r <= srd_r;
    if (st_r == smc_pkg::BK_READ2) b_r <= srd_r;
    if (st_r == smc_pkg::BK_EXEC) neg_r <= a_r[W-1] ^ b_r[W-1];
    if (st_r == smc_pkg::BK_READ)
      in_mem_r <= ({{(32-AW){1'b0}}, ins_r.addr} < 32'(MEM_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (s_we) stk_mem[s_waddr] <= s_wdata;
    if (s_rd) srd_r <= stk_mem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (m_we) dmem[m_waddr] <= m_wdata;
    mrd_r <= dmem[MAW'(ins_r.addr)];
  end
endmodule
`default_nettype wire

// File: sv/stack_machine_core.sv
// Top level of the stack machine core: front decode queue plus back execution unit.
// Depends on smc_pkg, smc_front and smc_back.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall  | in_command, in_immediate, in_address
//   out_    | output    | out_valid / out_stall| out_value, out_status
//
// Back end: push, load and store pass READ and WRITE; add and sub READ, READ2, EXEC and
// WRITE; mul also MUL, MUL2, MUL3 (three half-width products); print also EMIT for its
// transfer; div also DIV on the one-bit-per-cycle divider, then DIVFIX. A fault at the
// stack check goes from READ to EMIT. After reset the back end clears data memory while
// instructions wait in the queue; a stalled result holds the back end at its next item.
`default_nettype none
module stack_machine_core #(
  parameter int STACK_DEPTH = 256,
  parameter int MEM_DEPTH   = 128
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire  [smc_pkg::CMD_W-1:0]            in_command,
  input  wire  signed [smc_pkg::IMM_W-1:0]     in_immediate,
  input  wire  [smc_pkg::ADDR_W-1:0]           in_address,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic signed [smc_pkg::WORD_W-1:0]    out_value,
  output logic [smc_pkg::ST_W-1:0]             out_status
);
  logic            q_valid, q_take, clearing;
  smc_pkg::instr_t q_data;

  smc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_immediate (in_immediate),
    .in_address   (in_address),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_take       (q_take)
  );

  smc_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .MEM_DEPTH   (MEM_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_take     (q_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .out_status (out_status),
    .clearing   (clearing)
  );

  // No instruction leaves the queue while data memory is still being cleared.
  a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !q_take) else $error("instruction taken during memory clear");

  // A faulting result always carries a zero value.
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != smc_pkg::ST_PRINT) |-> (out_value == '0))
    else $error("fault result with nonzero value");

  // The queue only drains when it holds something.
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> q_valid) else $error("queue taken while empty");
endmodule
`default_nettype wire

// File: tb/tb_stack_machine_core.sv
// Testbench for stack_machine_core: drives instruction streams and checks print and fault results.
// Depends on smc_pkg and the stack_machine_core RTL; the expected-result predictor lives in a class.
`default_nettype none
module tb_stack_machine_core;
  localparam int STACK_DEPTH = 256;
  localparam int MEM_DEPTH   = 128;
  localparam int WORD_W      = smc_pkg::WORD_W;
  localparam int IMM_W       = smc_pkg::IMM_W;
  localparam int ADDR_W      = smc_pkg::ADDR_W;
  localparam int CMD_W       = smc_pkg::CMD_W;
  localparam int ST_W        = smc_pkg::ST_W;

  typedef struct {
    logic [WORD_W-1:0] value;
    smc_pkg::status_t  status;
  } result_t;

  class stack_scoreboard;
    logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
    logic [WORD_W-1:0] data_mem [MEM_DEPTH];
    int unsigned       depth;
    result_t           pending_results[$];
    int unsigned       mismatches;

    function new();
      depth = 0;
      mismatches = 0;
      foreach (data_mem[i]) data_mem[i] = '0;
    endfunction

    function void add_result(logic [WORD_W-1:0] v, smc_pkg::status_t s);
      result_t r;
      r.value = v;
      r.status = s;
      pending_results.insert(pending_results.size(), r);
    endfunction

    // Applies one accepted instruction to the shadow stack and memory.
    function void note_instruction(smc_pkg::cmd_t c, logic [IMM_W-1:0] imm,
                                   logic [ADDR_W-1:0] addr);
      logic [WORD_W-1:0] a, b, r, qa, qb;
      case (c)
        smc_pkg::CMD_PUSH, smc_pkg::CMD_LOAD: begin
          if (depth >= STACK_DEPTH) begin
            add_result('0, smc_pkg::ST_OVER);
          end else begin
            if (c == smc_pkg::CMD_PUSH) r = {{(WORD_W-IMM_W){imm[IMM_W-1]}}, imm};
            else r = (addr < MEM_DEPTH) ? data_mem[addr] : '0;
            stack_mem[depth] = r;
            depth++;
          end
        end
        smc_pkg::CMD_STORE: begin
          if (depth < 1) begin
            add_result('0, smc_pkg::ST_UNDER);
          end else begin
            depth--;
            if (addr < MEM_DEPTH) data_mem[addr] = stack_mem[depth];
          end
        end
        smc_pkg::CMD_PRINT: begin
          if (depth < 1) begin
            add_result('0, smc_pkg::ST_UNDER);
          end else begin
            depth--;
            add_result(stack_mem[depth], smc_pkg::ST_PRINT);
          end
        end
        default: begin
          if (depth < 2) begin
            add_result('0, smc_pkg::ST_UNDER);
          end else begin
            a = stack_mem[depth-1];
            b = stack_mem[depth-2];
            if (c == smc_pkg::CMD_DIV && a == '0) begin
              add_result('0, smc_pkg::ST_DIVZ);
            end else begin
              case (c)
                smc_pkg::CMD_ADD: r = a + b;
                smc_pkg::CMD_SUB: r = b - a;
                smc_pkg::CMD_MUL: r = a * b;
                default: begin
                  qa = a[WORD_W-1] ? -a : a;
                  qb = b[WORD_W-1] ? -b : b;
                  r = qb / qa;
                  if (a[WORD_W-1] != b[WORD_W-1]) r = -r;
                end
              endcase
              depth--;
              stack_mem[depth-1] = r;
            end
          end
        end
      endcase
    endfunction

    function void check_result(logic [WORD_W-1:0] v, logic [ST_W-1:0] s);
      result_t e;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %0d status %0d", $signed(v), s);
        return;
      end
      e = pending_results.pop_front();
      if (v !== e.value || s !== e.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected value %0d status %0d, got value %0d status %0d",
                   $signed(e.value), e.status, $signed(v), s);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [CMD_W-1:0] in_command;
  logic signed [IMM_W-1:0] in_immediate;
  logic [ADDR_W-1:0] in_address;
  logic out_valid;
  logic out_stall;
  logic signed [WORD_W-1:0] out_value;
  logic [ST_W-1:0] out_status;

  stack_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned sent_items;

  stack_machine_core #(.STACK_DEPTH(STACK_DEPTH), .MEM_DEPTH(MEM_DEPTH)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_immediate(in_immediate), .in_address(in_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_value(out_value), .out_status(out_status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

  // Receiver side: random stall, checks each accepted result transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_value, out_status);
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [31:0] w;
    w = $urandom;
    return w[ADDR_W-1:0];
  endfunction

  // Sends one instruction; valid stays high across back-to-back transfers.
  task automatic send_instruction(smc_pkg::cmd_t c, logic [IMM_W-1:0] imm,
                                  logic [ADDR_W-1:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= c;
    in_immediate <= imm;
    in_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_instruction(c, imm, addr);
    sent_items++;
  endtask

  task automatic send_random_immediate();
    logic [IMM_W-1:0] imm;
    case ($urandom_range(4))
      0: imm = 32'h8000_0000;
      1: imm = 32'h7fff_ffff;
      2: imm = $urandom_range(7) - 3;
      default: imm = $urandom;
    endcase
    send_instruction(smc_pkg::CMD_PUSH, imm, rand_addr());
  endtask

  // A well-formed burst: a few pushes and loads, arithmetic, then store or print.
  task automatic send_program();
    int unsigned n;
    smc_pkg::cmd_t op;
    n = $urandom_range(2, 5);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) send_instruction(smc_pkg::CMD_LOAD, $urandom, rand_addr());
      else send_random_immediate();
    end
    for (int i = 0; i < n - 1; i++) begin
      op = smc_pkg::cmd_t'($urandom_range(smc_pkg::CMD_ADD, smc_pkg::CMD_DIV));
      send_instruction(op, $urandom, rand_addr());
    end
    if ($urandom_range(1)) send_instruction(smc_pkg::CMD_STORE, $urandom, rand_addr());
    else send_instruction(smc_pkg::CMD_PRINT, $urandom, rand_addr());
  endtask

  task automatic run_random_phase(int unsigned items);
    int unsigned stop_at;
    stop_at = sent_items + items;
    while (sent_items < stop_at) begin
      if ($urandom_range(9) < 8) send_program();
      else send_instruction(smc_pkg::cmd_t'($urandom_range(7)), $urandom, rand_addr());
    end
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    sb = new();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    sent_items = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = '0;
    in_immediate = '0;
    in_address = '0;
    out_stall = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: underflow on empty stack, extremes, wrap cases, divide faults.
    send_instruction(smc_pkg::CMD_PRINT, '0, '0);
    send_instruction(smc_pkg::CMD_STORE, '0, 7'd5);
    send_instruction(smc_pkg::CMD_ADD, '0, '0);
    send_instruction(smc_pkg::CMD_LOAD, '0, 7'd127);
    send_instruction(smc_pkg::CMD_PRINT, '0, '0);
    send_instruction(smc_pkg::CMD_PUSH, 32'h8000_0000, '0);
    send_instruction(smc_pkg::CMD_PUSH, 32'h7fff_ffff, '0);
    send_instruction(smc_pkg::CMD_MUL, '0, '0);
    send_instruction(smc_pkg::CMD_PUSH, 32'h8000_0000, '0);
    send_instruction(smc_pkg::CMD_MUL, '0, '0);
    send_instruction(smc_pkg::CMD_PUSH, 32'hffff_ffff, '0);
    send_instruction(smc_pkg::CMD_DIV, '0, '0);
    send_instruction(smc_pkg::CMD_PUSH, '0, '0);
    send_instruction(smc_pkg::CMD_DIV, '0, '0);
    send_instruction(smc_pkg::CMD_SUB, '0, '0);
    send_instruction(smc_pkg::CMD_STORE, '0, 7'd127);
    send_instruction(smc_pkg::CMD_LOAD, '0, 7'd127);
    send_instruction(smc_pkg::CMD_PUSH, 32'hffff_fff9, '0);
    send_instruction(smc_pkg::CMD_PUSH, 32'd2, '0);
    send_instruction(smc_pkg::CMD_DIV, '0, '0);
    send_instruction(smc_pkg::CMD_ADD, '0, '0);
    send_instruction(smc_pkg::CMD_PRINT, '0, '0);
    // Fill the stack to overflow, then empty it by prints.
    while (sb.depth < STACK_DEPTH) send_instruction(smc_pkg::CMD_PUSH, $urandom, '0);
    send_instruction(smc_pkg::CMD_PUSH, 32'd1, '0);
    send_instruction(smc_pkg::CMD_LOAD, '0, '0);
    while (sb.depth > 0) send_instruction(smc_pkg::CMD_PRINT, '0, '0);
    in_valid <= 1'b0;
    @(posedge clk);

    send_idle_pct = 37;
    recv_idle_pct = 67;
    run_random_phase(370);
    send_idle_pct = 67;
    recv_idle_pct = 37;
    run_random_phase(370);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(370);
    drain();

    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: sim.f
sv/smc_pkg.sv
sv/smc_front.sv
sv/smc_divider.sv
sv/smc_back.sv
sv/stack_machine_core.sv
tb/tb_stack_machine_core.sv
